// ----- src/permutation_with_inverse_swaps_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the permutation with inverse block
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_WITH_INVERSE_SWAPS_DEFINES_SVH
`define PERMUTATION_WITH_INVERSE_SWAPS_DEFINES_SVH

// same-cycle implication
`define PWIS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PWIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pwis_pkg.sv -----
// ----------------------------------------------------------------------------
// pwis_pkg
// Types and constants shared by the permutation with inverse block.
// ----------------------------------------------------------------------------
package pwis_pkg;

  localparam int SIZE_DEFAULT = 64;
  localparam int IDX_W        = 6;
  localparam int OP_W         = 2;
  localparam int CFG_W        = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 24;

  localparam logic [CFG_W-1:0] ACTIVE_SIZE_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_LOAD   = 2'd1,
    OP_RIGHT  = 2'd2,
    OP_LEFT   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_SIZE = 1'b0,
    CFG_LOAD_INV    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic load;
    logic rd_a;
    logic rd_b;
    logic cap_a;
    logic cap_b;
    logic sw1;
    logic sw2;
    logic sw3;
    logic sw4;
    logic res_a;
    logic res_b;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_err;
    logic out_busy;
    op_t  op;
  } stat_t;

endpackage

// ----- src/permutation_with_inverse_swaps.sv -----
// From input accept to m_tvalid: a lookup passes RB_A, RB_B, RB_CAP and DONE, a load
// LOAD before them, a transposition RD_A, RD_B, RD_CAP and T1-T4 before them, and a
// range error DONE alone; m_tvalid is registered after DONE. One item at a time, and
// DONE waits while the output stalls. Each map RAM has a single port, so its reads and
// writes are serialized, reads registered. After rst a clearing pass writes the
// identity into both maps with s_tready low; config writes are taken throughout.
// ----------------------------------------------------------------------------
// permutation_with_inverse_swaps
// Permutation and inverse tables with lookup, load and transposition requests.
// ----------------------------------------------------------------------------
module permutation_with_inverse_swaps #(
  parameter int SIZE = pwis_pkg::SIZE_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pwis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwis_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pwis_pkg::IN_DATA_W-1:0]  s_tdata,   // index_a, index_b
  input  logic [pwis_pkg::OP_W-1:0]       s_tuser,   // op
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pwis_pkg::OUT_DATA_W-1:0] m_tdata,   // fwd_of_a, fwd_of_b, inv_of_a, inv_of_b
  output logic                            m_tuser    // range_error
);

  pwis_pkg::cmd_t  cmd;
  pwis_pkg::stat_t stat;

  pwis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pwis_dp #(.SIZE(SIZE)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- src/pwis_ram.sv -----
// ----------------------------------------------------------------------------
// pwis_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module pwis_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- src/pwis_ctrl.sv -----
// ----------------------------------------------------------------------------
// pwis_ctrl
// Sequencer: clearing pass, operation steps, readback, result push.
// ----------------------------------------------------------------------------
module pwis_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  pwis_pkg::stat_t stat,
  output pwis_pkg::cmd_t  cmd
);

  typedef enum logic [13:0] {
    ST_INIT   = 14'b00000000000001,
    ST_IDLE   = 14'b00000000000010,
    ST_LOAD   = 14'b00000000000100,
    ST_RD_A   = 14'b00000000001000,
    ST_RD_B   = 14'b00000000010000,
    ST_RD_CAP = 14'b00000000100000,
    ST_T1     = 14'b00000001000000,
    ST_T2     = 14'b00000010000000,
    ST_T3     = 14'b00000100000000,
    ST_T4     = 14'b00001000000000,
    ST_RB_A   = 14'b00010000000000,
    ST_RB_B   = 14'b00100000000000,
    ST_RB_CAP = 14'b01000000000000,
    ST_DONE   = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (stat.in_err) begin
            state_next = ST_DONE;
          end else begin
            case (stat.op)
              pwis_pkg::OP_LOOKUP: state_next = ST_RB_A;
              pwis_pkg::OP_LOAD:   state_next = ST_LOAD;
              default:             state_next = ST_RD_A;
            endcase
          end
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_RB_A;
      end
      ST_RD_A: begin
        cmd.rd_a   = 1'b1;
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.rd_b   = 1'b1;
        cmd.cap_a  = 1'b1;
        state_next = ST_RD_CAP;
      end
      ST_RD_CAP: begin
        cmd.cap_b  = 1'b1;
        state_next = ST_T1;
      end
      ST_T1: begin
        cmd.sw1    = 1'b1;
        state_next = ST_T2;
      end
      ST_T2: begin
        cmd.sw2    = 1'b1;
        state_next = ST_T3;
      end
      ST_T3: begin
        cmd.sw3    = 1'b1;
        state_next = ST_T4;
      end
      ST_T4: begin
        cmd.sw4    = 1'b1;
        state_next = ST_RB_A;
      end
      ST_RB_A: begin
        cmd.rd_a   = 1'b1;
        state_next = ST_RB_B;
      end
      ST_RB_B: begin
        cmd.rd_b   = 1'b1;
        cmd.res_a  = 1'b1;
        state_next = ST_RB_CAP;
      end
      ST_RB_CAP: begin
        cmd.res_b  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

// ----- src/pwis_dp.sv -----
// ----------------------------------------------------------------------------
// pwis_dp
// Datapath: config registers, range check, both map RAMs, result registers.
// ----------------------------------------------------------------------------
module pwis_dp #(
  parameter int SIZE = pwis_pkg::SIZE_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pwis_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwis_pkg::CFG_W-1:0]       cfg_data,
  input  logic [pwis_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [pwis_pkg::OP_W-1:0]        s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pwis_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                             m_tuser,
  input  pwis_pkg::cmd_t                   cmd,
  output pwis_pkg::stat_t                  stat
);

  localparam int          AW     = $clog2(SIZE);
  localparam logic [31:0] SIZE_W = 32'(SIZE);
  localparam int          IW     = pwis_pkg::IDX_W;

  logic [pwis_pkg::CFG_W-1:0] active_size;
  logic                       load_inv;
  logic [AW-1:0]              clr_cnt;

  logic [IW-1:0] in_a, in_b, a_q, b_q;
  logic          left_q;
  logic [AW-1:0] fa_q, fb_q, ia_q, ib_q, p_q, ua, ub;
  logic [IW-1:0] res_fa, res_fb, res_ia, res_ib;
  logic          res_err;

  logic          f_en, f_we, i_en, i_we;
  logic [AW-1:0] f_addr, f_wdata, f_rdata, i_addr, i_wdata, i_rdata;
  logic          m1_en, m1_we, m2_en, m2_we;
  logic [AW-1:0] m1_addr, m1_wdata, m2_addr, m2_wdata, m2_rdata;

  assign in_a = s_tdata[IW-1:0];
  assign in_b = s_tdata[2*IW-1:IW];

  assign stat.in_err = (7'(in_a) >= active_size) || (7'(in_b) >= active_size) ||
                       (32'(in_a) >= SIZE_W) || (32'(in_b) >= SIZE_W);
  assign stat.op         = pwis_pkg::op_t'(s_tuser);
  assign stat.clear_last = (clr_cnt == AW'(SIZE - 1));
  assign stat.out_busy   = m_tvalid && !m_tready;

  assign ua       = left_q ? ia_q : fa_q;
  assign ub       = left_q ? ib_q : fb_q;
  assign m2_rdata = left_q ? f_rdata : i_rdata;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= pwis_pkg::ACTIVE_SIZE_RESET;
      load_inv    <= 1'b0;
    end else if (cfg_we) begin
      unique case (pwis_pkg::cfg_idx_t'(cfg_index))
        pwis_pkg::CFG_ACTIVE_SIZE: active_size <= cfg_data;
        pwis_pkg::CFG_LOAD_INV:    load_inv    <= cfg_data[0];
        default:                   active_size <= active_size;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear && !stat.clear_last) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // RAM requests; m1 is the map swapped at a/b, m2 the map swapped at the images
  always_comb begin
    m1_en = 1'b0; m1_we = 1'b0; m1_addr = '0; m1_wdata = '0;
    m2_en = 1'b0; m2_we = 1'b0; m2_addr = '0; m2_wdata = '0;
    if (cmd.sw1) begin
      m1_en = 1'b1; m1_we = 1'b1; m1_addr = AW'(a_q); m1_wdata = ub;
      m2_en = 1'b1; m2_addr = ua;
    end
    if (cmd.sw2) begin
      m1_en = 1'b1; m1_we = 1'b1; m1_addr = AW'(b_q); m1_wdata = ua;
      m2_en = 1'b1; m2_addr = ub;
    end
    if (cmd.sw3) begin
      m2_en = 1'b1; m2_we = 1'b1; m2_addr = ua; m2_wdata = m2_rdata;
    end
    if (cmd.sw4) begin
      m2_en = 1'b1; m2_we = 1'b1; m2_addr = ub; m2_wdata = p_q;
    end

    if (left_q) begin
      f_en = m2_en; f_we = m2_we; f_addr = m2_addr; f_wdata = m2_wdata;
      i_en = m1_en; i_we = m1_we; i_addr = m1_addr; i_wdata = m1_wdata;
    end else begin
      f_en = m1_en; f_we = m1_we; f_addr = m1_addr; f_wdata = m1_wdata;
      i_en = m2_en; i_we = m2_we; i_addr = m2_addr; i_wdata = m2_wdata;
    end

    if (cmd.clear) begin
      f_en = 1'b1; f_we = 1'b1; f_addr = clr_cnt; f_wdata = clr_cnt;
      i_en = 1'b1; i_we = 1'b1; i_addr = clr_cnt; i_wdata = clr_cnt;
    end
    if (cmd.load) begin
      f_en = 1'b1; f_we = 1'b1;
      i_en = 1'b1; i_we = 1'b1;
      if (load_inv) begin
        i_addr = AW'(a_q); i_wdata = AW'(b_q);
        f_addr = AW'(b_q); f_wdata = AW'(a_q);
      end else begin
        f_addr = AW'(a_q); f_wdata = AW'(b_q);
        i_addr = AW'(b_q); i_wdata = AW'(a_q);
      end
    end
    if (cmd.rd_a) begin
      f_en = 1'b1; f_we = 1'b0; f_addr = AW'(a_q);
      i_en = 1'b1; i_we = 1'b0; i_addr = AW'(a_q);
    end
    if (cmd.rd_b) begin
      f_en = 1'b1; f_we = 1'b0; f_addr = AW'(b_q);
      i_en = 1'b1; i_we = 1'b0; i_addr = AW'(b_q);
    end
  end

  pwis_ram #(.WIDTH(AW), .DEPTH(SIZE)) u_fwd_ram (
    .clk   (clk),
    .en    (f_en),
    .we    (f_we),
    .addr  (f_addr),
    .wdata (f_wdata),
    .rdata (f_rdata)
  );

  pwis_ram #(.WIDTH(AW), .DEPTH(SIZE)) u_inv_ram (
    .clk   (clk),
    .en    (i_en),
    .we    (i_we),
    .addr  (i_addr),
    .wdata (i_wdata),
    .rdata (i_rdata)
  );

  // operands, intermediate reads, staged result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      a_q     <= in_a;
      b_q     <= in_b;
      left_q  <= (stat.op == pwis_pkg::OP_LEFT);
      res_fa  <= '0;
      res_fb  <= '0;
      res_ia  <= '0;
      res_ib  <= '0;
      res_err <= stat.in_err;
    end
    if (cmd.cap_a) begin
      fa_q <= f_rdata;
      ia_q <= i_rdata;
    end
    if (cmd.cap_b) begin
      fb_q <= f_rdata;
      ib_q <= i_rdata;
    end
    if (cmd.sw2) begin
      p_q <= m2_rdata;
    end
    if (cmd.res_a) begin
      res_fa <= IW'(f_rdata);
      res_ia <= IW'(i_rdata);
    end
    if (cmd.res_b) begin
      res_fb <= IW'(f_rdata);
      res_ib <= IW'(i_rdata);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      m_tdata <= {res_ib, res_ia, res_fb, res_fa};
      m_tuser <= res_err;
    end
  end

endmodule

// ----- src/pwis_sva.sv -----
// ----------------------------------------------------------------------------
// pwis_sva
// Port-level checks on the permutation with inverse block.
// ----------------------------------------------------------------------------
`include "permutation_with_inverse_swaps_defines.svh"

module pwis_sva (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pwis_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser
);

  `PWIS_ASSERT_SAME(a_err_zero, m_tvalid && m_tuser, m_tdata == '0, "range error result not zero")
  `PWIS_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while busy")
  `PWIS_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid), "result too early")
  `PWIS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind permutation_with_inverse_swaps pwis_sva u_sva (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: permutation with inverse, transposition engine
// Drives lookup, load and transposition requests through the stream input,
// predicts both maps in the bench and checks every result field by field.
// Covers identity after reset, map loads in both directions, right and left
// transpositions, range errors at several active sizes (1 and 10 included),
// random idling on both sides and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import pwis_pkg::*;

  localparam int NPTS       = SIZE_DEFAULT;
  localparam int WDOG_LIMIT = 3000;
  localparam int DRAIN_CYC  = 16;

  typedef struct packed {
    logic [IDX_W-1:0] fwd_a;
    logic [IDX_W-1:0] fwd_b;
    logic [IDX_W-1:0] inv_a;
    logic [IDX_W-1:0] inv_b;
    logic             range_err;
  } perm_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [OP_W-1:0]       s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  // bench copy of both maps and the registers
  logic [IDX_W-1:0] fwd_tab [NPTS];
  logic [IDX_W-1:0] inv_tab [NPTS];
  logic [CFG_W-1:0] cur_active_size;
  logic             cur_load_inv;

  perm_result_t expected_q[$];

  int  n_requests;
  int  n_results;
  int  n_range_err;
  int  n_cfg_writes;
  int  n_fail;
  int  hold_request;
  int  quiet_cycles;
  bit  src_idle_en;
  bit  sink_idle_en;

  permutation_with_inverse_swaps #(.SIZE(NPTS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // apply one request to the bench maps and return what the block must answer
  function automatic perm_result_t apply_op(op_t op, logic [IDX_W-1:0] a,
                                            logic [IDX_W-1:0] b);
    perm_result_t     r;
    logic [CFG_W-1:0] limit;
    logic [IDX_W-1:0] x;
    logic [IDX_W-1:0] y;
    logic [IDX_W-1:0] t;
    limit = (cur_active_size < NPTS) ? cur_active_size : CFG_W'(NPTS);
    r = '0;
    if ({1'b0, a} >= limit || {1'b0, b} >= limit) begin
      r.range_err = 1'b1;
      return r;
    end
    case (op)
      OP_LOAD: begin
        if (cur_load_inv) begin
          inv_tab[a] = b;
          fwd_tab[b] = a;
        end else begin
          fwd_tab[a] = b;
          inv_tab[b] = a;
        end
      end
      OP_RIGHT: begin
        t = fwd_tab[a]; fwd_tab[a] = fwd_tab[b]; fwd_tab[b] = t;
        x = fwd_tab[a];
        y = fwd_tab[b];
        t = inv_tab[x]; inv_tab[x] = inv_tab[y]; inv_tab[y] = t;
      end
      OP_LEFT: begin
        x = inv_tab[a];
        y = inv_tab[b];
        t = fwd_tab[x]; fwd_tab[x] = fwd_tab[y]; fwd_tab[y] = t;
        t = inv_tab[a]; inv_tab[a] = inv_tab[b]; inv_tab[b] = t;
      end
      default: ;
    endcase
    r.fwd_a = fwd_tab[a];
    r.fwd_b = fwd_tab[b];
    r.inv_a = inv_tab[a];
    r.inv_b = inv_tab[b];
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(op_t op, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    perm_result_t r;
    if (src_idle_en) begin
      while ($urandom_range(99) < 33) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= IN_DATA_W'({b, a});
    do @(posedge clk); while (!s_tready);
    r = apply_op(op, a, b);
    expected_q.push_back(r);
    n_requests++;
    if (r.range_err) n_range_err++;
    @(negedge clk);
  endtask

  task automatic wait_idle(int extra);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    wait_idle(DRAIN_CYC);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ACTIVE_SIZE) cur_active_size = val;
    else cur_load_inv = val[0];
    n_cfg_writes++;
  endtask

  task automatic send_random(int count);
    int               r;
    op_t              op;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    int               lim;
    lim = (cur_active_size < NPTS) ? int'(cur_active_size) : NPTS;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 20) op = OP_LOOKUP;
      else if (r < 35) op = OP_LOAD;
      else if (r < 67) op = OP_RIGHT;
      else op = OP_LEFT;
      a = ($urandom_range(9) < 8) ? IDX_W'($urandom_range(lim - 1)) : IDX_W'($urandom_range(63));
      b = ($urandom_range(9) < 8) ? IDX_W'($urandom_range(lim - 1)) : IDX_W'($urandom_range(63));
      send_request(op, a, b);
    end
  endtask

  task automatic test_directed_ops;
    send_request(OP_LOOKUP, 6'd0, 6'd63);
    send_request(OP_LOOKUP, 6'd63, 6'd0);
    send_request(OP_LOAD, 6'd63, 6'd0);
    send_request(OP_LOAD, 6'd0, 6'd63);
    send_request(OP_RIGHT, 6'd0, 6'd63);
    send_request(OP_LEFT, 6'd5, 6'd63);
    send_request(OP_RIGHT, 6'd7, 6'd7);
    send_request(OP_LEFT, 6'd9, 6'd9);
    send_request(OP_RIGHT, 6'd21, 6'd42);
    send_request(OP_LEFT, 6'd42, 6'd21);
    write_reg(CFG_LOAD_INV, 7'd1);
    send_request(OP_LOAD, 6'd1, 6'd2);
    send_request(OP_LOOKUP, 6'd1, 6'd2);
    send_request(OP_RIGHT, 6'd1, 6'd2);
    send_request(OP_LEFT, 6'd2, 6'd1);
    write_reg(CFG_LOAD_INV, 7'd0);
  endtask

  // shrunk size keeps large stored values, which still index the tables
  task automatic test_range_and_shrink;
    send_request(OP_LOAD, 6'd3, 6'd60);
    write_reg(CFG_ACTIVE_SIZE, 7'd10);
    send_request(OP_RIGHT, 6'd3, 6'd4);
    send_request(OP_LEFT, 6'd3, 6'd9);
    send_request(OP_LOOKUP, 6'd10, 6'd0);
    send_request(OP_LOOKUP, 6'd0, 6'd10);
    send_request(OP_RIGHT, 6'd63, 6'd63);
    send_request(OP_LOAD, 6'd9, 6'd9);
    write_reg(CFG_ACTIVE_SIZE, 7'd1);
    send_request(OP_LOOKUP, 6'd0, 6'd0);
    send_request(OP_RIGHT, 6'd0, 6'd1);
    send_request(OP_LEFT, 6'd0, 6'd0);
    write_reg(CFG_ACTIVE_SIZE, 7'd64);
  endtask

  task automatic test_random_phases;
    logic [CFG_W-1:0] sizes [6];
    bit               invs  [6];
    sizes = '{7'd64, 7'd1, 7'd2, 7'd37, 7'd64, CFG_W'($urandom_range(3, 63))};
    invs  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_ACTIVE_SIZE, sizes[p]);
      write_reg(CFG_LOAD_INV, 7'(invs[p]));
      // one phase runs with both sides always ready
      src_idle_en  = (p != 4);
      sink_idle_en = (p != 4);
      send_random((p == 1) ? 120 : 255);
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_input_stall;
    write_reg(CFG_ACTIVE_SIZE, 7'd64);
    src_idle_en  = 1'b0;
    hold_request = 400;
    send_random(30);
    src_idle_en  = 1'b1;
  endtask

  // result sink: random idling plus a long hold on request
  initial begin : result_sink
    int stall;
    stall    = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !rst && (!sink_idle_en || $urandom_range(99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    perm_result_t e;
    perm_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.fwd_a     = m_tdata[IDX_W-1:0];
      got.fwd_b     = m_tdata[2*IDX_W-1:IDX_W];
      got.inv_a     = m_tdata[3*IDX_W-1:2*IDX_W];
      got.inv_b     = m_tdata[4*IDX_W-1:3*IDX_W];
      got.range_err = m_tuser;
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
        n_fail++;
      end else begin
        e = expected_q.pop_front();
        if (got.fwd_a !== e.fwd_a) begin
          $error("fwd_of_a exp %0d got %0d", e.fwd_a, got.fwd_a); n_fail++;
        end
        if (got.fwd_b !== e.fwd_b) begin
          $error("fwd_of_b exp %0d got %0d", e.fwd_b, got.fwd_b); n_fail++;
        end
        if (got.inv_a !== e.inv_a) begin
          $error("inv_of_a exp %0d got %0d", e.inv_a, got.inv_a); n_fail++;
        end
        if (got.inv_b !== e.inv_b) begin
          $error("inv_of_b exp %0d got %0d", e.inv_b, got.inv_b); n_fail++;
        end
        if (got.range_err !== e.range_err) begin
          $error("range_error exp %0d got %0d", e.range_err, got.range_err); n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_ACTIVE_SIZE;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = OP_LOOKUP;
    n_requests   = 0;
    n_results    = 0;
    n_range_err  = 0;
    n_cfg_writes = 0;
    n_fail       = 0;
    hold_request = 0;
    quiet_cycles = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    cur_active_size = ACTIVE_SIZE_RESET;
    cur_load_inv    = 1'b0;
    for (int i = 0; i < NPTS; i++) begin
      fwd_tab[i] = IDX_W'(i);
      inv_tab[i] = IDX_W'(i);
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_ops;
    test_range_and_shrink;
    test_random_phases;
    test_input_stall;

    wait_idle(20);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      n_fail++;
    end
    $display("ran %0d requests (%0d out of range) and %0d results, %0d register writes",
             n_requests, n_range_err, n_results, n_cfg_writes);
    $display("active sizes 1 to 64, both load directions, idling and a long output hold");
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
